/* sv/solt_pkg.sv */
// Shared constants, codes and the cell command type of the self-organizing lookup table.
package solt_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int KEY_BITS_DEF    = 32;
    localparam int COUNT_BITS_DEF  = 16;

    // Fixed field widths.
    localparam int SLOT_BITS    = 6;
    localparam int POS_BITS     = 6;
    localparam int STRAT_BITS   = 2;
    localparam int ENTRIES_BITS = 7;
    localparam int ADDR_BITS    = 3;
    localparam int DATA_BITS    = 32;

    // Reordering strategies.
    localparam logic [STRAT_BITS-1:0] STRAT_FRONT = 2'd0;
    localparam logic [STRAT_BITS-1:0] STRAT_PREV  = 2'd1;
    localparam logic [STRAT_BITS-1:0] STRAT_COUNT = 2'd2;

    // Request kinds.
    localparam logic MODE_SEARCH = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    // Register select, taken from address bit 2.
    localparam logic REG_STRATEGY = 1'b0;
    localparam logic REG_ENTRIES  = 1'b1;

    localparam logic [STRAT_BITS-1:0]   STRATEGY_RESET = STRAT_FRONT;
    localparam logic [ENTRIES_BITS-1:0] ENTRIES_RESET  = 7'd64;

    // Command broadcast from the control logic to every cell.
    typedef struct packed {
        logic                  probe;
        logic                  exec_load;
        logic                  exec_search;
        logic                  hit_any;
        logic [STRAT_BITS-1:0] strategy;
    } cell_cmd_t;

endpackage

/* sv/self_organizing_lookup_table_top.sv */
// Top level of the self-organizing lookup table: register port, request control and cell row.
//
// Requests arrive on the s_t* channel; each holds a mode, a key and a slot. A search looks
// for the key among the first entries_in_use entries and answers with a found flag and a
// position; a load writes the key into the entry at slot and answers with zeros. Results
// leave on the m_t* channel, exactly one per request, in order.
// Every entry is a cell of its own. At the edge that accepts a search all cells compare
// the key at once; at the following edge the lowest hit is picked and, where the strategy
// calls for it, the hit cell and its neighbor (or the front cell) swap contents in place.
// The result is written to the output register at that edge. No new request is taken
// while one executes, nor while the output register is full and not being taken.
// The output register holds a result until it is taken; while it is full and not being
// taken, s_tready stays low and the row keeps its contents.
// Reset clears every valid mark and hit counter, sets strategy to 0 (swap with front)
// and entries_in_use to 64. The configuration port is an APB slave with pready always
// high: strategy at address 0, entries_in_use at address 4.
module self_organizing_lookup_table_top
    import solt_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: mode, key, slot, zero fill.
    input  logic [((1+KEY_BITS+SLOT_BITS+7)/8)*8-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0: found, position, zero fill.
    output logic [((1+POS_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int PW    = (IDX_W > POS_BITS) ? IDX_W : POS_BITS;
    localparam int OUT_W = ((1+POS_BITS+7)/8)*8;

    // Input field split.
    logic                 in_mode;
    logic [KEY_BITS-1:0]  in_key;
    logic [SLOT_BITS-1:0] in_slot;

    assign in_mode = s_tdata[0];
    assign in_key  = s_tdata[KEY_BITS:1];
    assign in_slot = s_tdata[KEY_BITS+SLOT_BITS:KEY_BITS+1];

    // Configuration registers.
    logic [STRAT_BITS-1:0]   strategy_reg;
    logic [ENTRIES_BITS-1:0] entries_reg;
    logic                    cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strategy_reg <= STRATEGY_RESET;
            entries_reg  <= ENTRIES_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_ENTRIES)
            begin
                entries_reg <= pwdata[ENTRIES_BITS-1:0];
            end
            else
            begin
                strategy_reg <= pwdata[STRAT_BITS-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_STRATEGY) ? DATA_BITS'(strategy_reg)
                                                : DATA_BITS'(entries_reg);

    // Request control: accept, then execute in the next cycle.
    logic                 accept;
    logic                 busy_reg;
    logic                 mode_reg;
    logic [KEY_BITS-1:0]  key_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic                 m_valid_reg;
    logic                 found_reg;
    logic [POS_BITS-1:0]  pos_reg;

    assign s_tready = !busy_reg && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg <= in_mode;
            key_reg  <= in_key;
            slot_reg <= in_slot;
        end
    end

    // Cell row and lowest-hit pick.
    cell_cmd_t             cmd;
    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] first_vec;
    logic [TABLE_DEPTH-1:0] swap_vec;
    logic                   hit_any;
    logic [PW-1:0]          hit_index;
    logic [PW-1:0]          pos_adj;

    logic [KEY_BITS-1:0]   cell_key [TABLE_DEPTH];
    logic                  cell_valid [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] cell_cnt [TABLE_DEPTH];
    logic [COUNT_BITS-1:0] cnt_up [TABLE_DEPTH];

    assign cmd.probe       = accept && (in_mode == MODE_SEARCH);
    assign cmd.exec_load   = busy_reg && (mode_reg == MODE_LOAD);
    assign cmd.exec_search = busy_reg && (mode_reg == MODE_SEARCH);
    assign cmd.hit_any     = hit_any;
    assign cmd.strategy    = strategy_reg;

    solt_pick #(
        .DEPTH (TABLE_DEPTH),
        .PW    (PW)
    ) u_pick (
        .match   (match_vec),
        .first   (first_vec),
        .hit_any (hit_any),
        .index   (hit_index)
    );

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        logic [KEY_BITS-1:0]   prev_key;
        logic                  prev_valid;
        logic [COUNT_BITS-1:0] prev_cnt;
        logic                  next_hit;
        logic                  next_swap;
        logic [COUNT_BITS-1:0] next_cnt;

        // Neighbor links; the ends of the row see an empty neighbor.
        if (i == 0)
        begin : g_head
            assign prev_key   = '0;
            assign prev_valid = 1'b0;
            assign prev_cnt   = '0;
        end
        else
        begin : g_link_prev
            assign prev_key   = cell_key[i-1];
            assign prev_valid = cell_valid[i-1];
            assign prev_cnt   = cell_cnt[i-1];
        end

        if (i == TABLE_DEPTH-1)
        begin : g_tail
            assign next_hit  = 1'b0;
            assign next_swap = 1'b0;
            assign next_cnt  = '0;
        end
        else
        begin : g_link_next
            assign next_hit  = first_vec[i+1];
            assign next_swap = swap_vec[i+1];
            assign next_cnt  = cnt_up[i+1];
        end

        solt_cell #(
            .INDEX      (i),
            .KEY_BITS   (KEY_BITS),
            .COUNT_BITS (COUNT_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .probe_key   (in_key),
            .item_key    (key_reg),
            .item_slot   (slot_reg),
            .entries     (entries_reg),
            .hit         (first_vec[i]),
            .next_hit    (next_hit),
            .next_swap   (next_swap),
            .next_cnt    (next_cnt),
            .prev_key    (prev_key),
            .prev_valid  (prev_valid),
            .prev_cnt    (prev_cnt),
            .front_key   (cell_key[0]),
            .front_valid (cell_valid[0]),
            .match       (match_vec[i]),
            .cell_key    (cell_key[i]),
            .cell_valid  (cell_valid[i]),
            .cell_cnt    (cell_cnt[i]),
            .swap_up     (swap_vec[i]),
            .cnt_up      (cnt_up[i])
        );
    end

    // Count ordering reports the position after the forward swap.
    assign pos_adj = hit_index - PW'(|swap_vec);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            if (cmd.exec_search && hit_any)
            begin
                found_reg <= 1'b1;
                pos_reg   <= pos_adj[POS_BITS-1:0];
            end
            else
            begin
                found_reg <= 1'b0;
                pos_reg   <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({pos_reg, found_reg});

endmodule

/* sv/solt_cell.sv */
// One table entry: key, valid mark and hit counter, with compare and neighbor swap logic.
module solt_cell
    import solt_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_cmd_t               cmd,
    input  logic [KEY_BITS-1:0]     probe_key,
    input  logic [KEY_BITS-1:0]     item_key,
    input  logic [SLOT_BITS-1:0]    item_slot,
    input  logic [ENTRIES_BITS-1:0] entries,
    input  logic                    hit,
    input  logic                    next_hit,
    input  logic                    next_swap,
    input  logic [COUNT_BITS-1:0]   next_cnt,
    input  logic [KEY_BITS-1:0]     prev_key,
    input  logic                    prev_valid,
    input  logic [COUNT_BITS-1:0]   prev_cnt,
    input  logic [KEY_BITS-1:0]     front_key,
    input  logic                    front_valid,
    output logic                    match,
    output logic [KEY_BITS-1:0]     cell_key,
    output logic                    cell_valid,
    output logic [COUNT_BITS-1:0]   cell_cnt,
    output logic                    swap_up,
    output logic [COUNT_BITS-1:0]   cnt_up
);

    localparam bit IS_FRONT = (INDEX == 0);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic                  valid_reg, valid_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  match_reg, match_next;
    logic                  in_range;
    logic                  slot_sel;
    logic [COUNT_BITS-1:0] cnt_inc;

    assign in_range = (INDEX < int'(entries));
    assign slot_sel = (int'(item_slot) == INDEX);

    // Saturating increment of this entry's counter.
    assign cnt_inc = (cnt_reg == COUNT_MAX) ? cnt_reg : cnt_reg + 1'b1;

    // A hit entry under count ordering moves forward when it overtakes its neighbor.
    assign swap_up = !IS_FRONT && hit && cmd.exec_search && (cmd.strategy == STRAT_COUNT)
                     && (cnt_inc > prev_cnt);

    // Next state of the entry.
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        cnt_next   = cnt_reg;
        match_next = match_reg;
        if (cmd.probe)
        begin
            match_next = valid_reg && (key_reg == probe_key) && in_range;
        end
        if (cmd.exec_load)
        begin
            if (slot_sel)
            begin
                key_next   = item_key;
                valid_next = 1'b1;
                cnt_next   = '0;
            end
        end
        else if (cmd.exec_search)
        begin
            case (cmd.strategy)
                STRAT_FRONT:
                begin
                    if (IS_FRONT)
                    begin
                        // The front takes the hit key when the hit lies further back.
                        if (cmd.hit_any && !hit)
                        begin
                            key_next   = item_key;
                            valid_next = 1'b1;
                        end
                    end
                    else if (hit)
                    begin
                        key_next   = front_key;
                        valid_next = front_valid;
                    end
                end
                STRAT_PREV:
                begin
                    if (!IS_FRONT && hit)
                    begin
                        key_next   = prev_key;
                        valid_next = prev_valid;
                    end
                    else if (next_hit)
                    begin
                        key_next   = item_key;
                        valid_next = 1'b1;
                    end
                end
                STRAT_COUNT:
                begin
                    if (hit)
                    begin
                        if (swap_up)
                        begin
                            key_next   = prev_key;
                            valid_next = prev_valid;
                            cnt_next   = prev_cnt;
                        end
                        else
                        begin
                            cnt_next = cnt_inc;
                        end
                    end
                    else if (next_swap)
                    begin
                        key_next   = item_key;
                        valid_next = 1'b1;
                        cnt_next   = next_cnt;
                    end
                end
                default:
                begin
                    key_next = key_reg;
                end
            endcase
        end
    end

    // Control state of the entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
            match_reg <= match_next;
        end
    end

    // The key itself is only meaningful once the entry is valid.
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign match      = match_reg;
    assign cell_key   = key_reg;
    assign cell_valid = valid_reg;
    assign cell_cnt   = cnt_reg;
    assign cnt_up     = cnt_inc;

endmodule

/* sv/solt_pick.sv */
// Picks the lowest matching entry from the row of compare results and encodes its index.
module solt_pick
    import solt_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int PW    = POS_BITS
)
(
    input  logic [DEPTH-1:0] match,
    output logic [DEPTH-1:0] first,
    output logic             hit_any,
    output logic [PW-1:0]    index
);

    // Isolate the lowest set bit.
    assign first   = match & (~match + 1'b1);
    assign hit_any = |match;

    // One-hot to binary.
    always_comb
    begin
        index = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first[i])
            begin
                index = index | PW'(i);
            end
        end
    end

endmodule

/* sv/solt_checker.sv */
// Port-level checks of the self-organizing lookup table, bound to its top level.
module solt_checker
    import solt_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [((1+KEY_BITS+SLOT_BITS+7)/8)*8-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [((1+POS_BITS+7)/8)*8-1:0] m_tdata
);

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Every accepted request shows its result once it has passed the busy and output registers.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("result missing two cycles after request");

    // The row takes no new request in the cycle after it accepts one.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another executes");

    // A load answers with an all-zero result.
    a_load_zero: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[0] == MODE_LOAD) |=> ##1 (m_tdata == '0))
        else $error("load request gave a nonzero result");

    // A miss reports position zero.
    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[POS_BITS:1] == '0))
        else $error("miss with nonzero position");

endmodule

bind self_organizing_lookup_table_top solt_checker #(
    .KEY_BITS (KEY_BITS)
) u_solt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* test/testbench.sv */
// Self-checking testbench for the self-organizing lookup table: directed table, random phases.
`timescale 1ns / 100ps

module testbench;
    import solt_pkg::*;

    localparam int DEPTH     = TABLE_DEPTH_DEF;
    localparam int KEY_W     = KEY_BITS_DEF;
    localparam int COUNT_W   = COUNT_BITS_DEF;
    localparam int REQ_W     = ((1 + KEY_W + SLOT_BITS + 7) / 8) * 8;
    localparam int RES_W     = ((1 + POS_BITS + 7) / 8) * 8;
    localparam int COUNT_TOP = (1 << COUNT_W) - 1;
    localparam int PHASES    = 7;
    localparam int PHASE_LEN = 147;
    localparam int POOL_SIZE = 12;

    // Strategy code that the block accepts but does not act on.
    localparam logic [STRAT_BITS-1:0] STRAT_UNUSED = 2'd3;

    typedef enum logic {ROW_REQUEST, ROW_WRITE} row_kind_t;
    typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_style_t;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] pos;
    } lookup_result_t;

    // One line of the directed table: a request or a register write.
    typedef struct packed {
        row_kind_t            kind;
        logic                 mode;
        logic [KEY_W-1:0]     key;
        logic [SLOT_BITS-1:0] slot;
        logic                 reg_sel;
        logic [DATA_BITS-1:0] value;
        logic                 typed;
        logic                 found;
        logic [POS_BITS-1:0]  pos;
    } directed_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [DATA_BITS-1:0] pwdata;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [REQ_W-1:0]     s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [RES_W-1:0]     m_tdata;

    // Shadow copy of the table and its registers.
    logic [KEY_W-1:0]        shadow_key   [DEPTH];
    logic                    shadow_valid [DEPTH];
    logic [COUNT_W-1:0]      shadow_count [DEPTH];
    logic [STRAT_BITS-1:0]   cur_strategy;
    logic [ENTRIES_BITS-1:0] cur_entries;

    lookup_result_t pending_results [$];
    int             mismatch_count;
    int             burst_left;
    bit             sender_paced;
    ready_style_t   ready_style;
    int             hold_request;

    directed_row_t  directed_rows [27];

    self_organizing_lookup_table_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic directed_row_t search_row(input logic [KEY_W-1:0] key,
                                                 input logic typed, input logic found,
                                                 input logic [POS_BITS-1:0] pos);
        return '{ROW_REQUEST, MODE_SEARCH, key, 6'd0, REG_STRATEGY, 32'd0, typed, found, pos};
    endfunction

    function automatic directed_row_t load_row(input logic [KEY_W-1:0] key,
                                               input logic [SLOT_BITS-1:0] slot);
        return '{ROW_REQUEST, MODE_LOAD, key, slot, REG_STRATEGY, 32'd0, 1'b1, 1'b0, 6'd0};
    endfunction

    function automatic directed_row_t write_row(input logic reg_sel,
                                                input logic [DATA_BITS-1:0] value);
        return '{ROW_WRITE, MODE_SEARCH, 32'd0, 6'd0, reg_sel, value, 1'b0, 1'b0, 6'd0};
    endfunction

    // Swap two table entries; the counters move only under the count-based strategy.
    function automatic void swap_entries(input int a, input int b, input bit with_count);
        logic [KEY_W-1:0]   k;
        logic               v;
        logic [COUNT_W-1:0] c;
        k = shadow_key[a];
        v = shadow_valid[a];
        shadow_key[a]   = shadow_key[b];
        shadow_valid[a] = shadow_valid[b];
        shadow_key[b]   = k;
        shadow_valid[b] = v;
        if (with_count)
        begin
            c = shadow_count[a];
            shadow_count[a] = shadow_count[b];
            shadow_count[b] = c;
        end
    endfunction

    // Apply one request to the shadow table and return the result it gives.
    function automatic lookup_result_t table_lookup(input logic mode,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [SLOT_BITS-1:0] slot);
        lookup_result_t res;
        int             limit;
        int             hit;
        res.found = 1'b0;
        res.pos   = '0;
        hit       = -1;
        if (mode == MODE_LOAD)
        begin
            shadow_key[slot]   = key;
            shadow_valid[slot] = 1'b1;
            shadow_count[slot] = '0;
            return res;
        end
        limit = (cur_entries > DEPTH) ? DEPTH : int'(cur_entries);
        for (int i = 0; i < limit; i++)
        begin
            if (hit < 0 && shadow_valid[i] && shadow_key[i] == key)
                hit = i;
        end
        if (hit < 0)
            return res;
        res.found = 1'b1;
        res.pos   = hit[POS_BITS-1:0];
        case (cur_strategy)
            STRAT_FRONT:
            begin
                if (hit != 0)
                    swap_entries(hit, 0, 1'b0);
            end
            STRAT_PREV:
            begin
                if (hit != 0)
                    swap_entries(hit, hit - 1, 1'b0);
            end
            STRAT_COUNT:
            begin
                if (shadow_count[hit] != COUNT_TOP[COUNT_W-1:0])
                    shadow_count[hit] = shadow_count[hit] + 1'b1;
                if (hit > 0 && shadow_count[hit] > shadow_count[hit-1])
                begin
                    swap_entries(hit, hit - 1, 1'b1);
                    res.pos = res.pos - 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Offer one request, wait for its handshake and record the expected result.
    task automatic send_request(input logic mode, input logic [KEY_W-1:0] key,
                                input logic [SLOT_BITS-1:0] slot, input logic typed,
                                input logic t_found, input logic [POS_BITS-1:0] t_pos);
        int             gap;
        lookup_result_t res;
        gap = 0;
        if (sender_paced)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            burst_left--;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(REQ_W-1-KEY_W-SLOT_BITS){1'b0}}, slot, key, mode};
        do
            @(posedge clk);
        while (!s_tready);
        res = table_lookup(mode, key, slot);
        if (typed)
        begin
            res.found = t_found;
            res.pos   = t_pos;
        end
        pending_results.push_back(res);
    endtask

    // Stop offering requests and wait until every result has been taken.
    task automatic await_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write followed by a read back, with the block idle.
    task automatic write_register(input logic reg_sel, input logic [DATA_BITS-1:0] value);
        logic [DATA_BITS-1:0] want;
        await_idle();
        if (reg_sel == REG_STRATEGY)
        begin
            cur_strategy = value[STRAT_BITS-1:0];
            want = DATA_BITS'(cur_strategy);
        end
        else
        begin
            cur_entries = value[ENTRIES_BITS-1:0];
            want = DATA_BITS'(cur_entries);
        end
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata != want)
        begin
            $display("%0t: register read back mismatch, expected %0h, actual %0h",
                     $time, want, prdata);
            mismatch_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Result checker: every taken result against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        lookup_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual found %0b position %0d",
                         $time, m_tdata[0], m_tdata[POS_BITS:1]);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.found)
                begin
                    $display("%0t: found mismatch, expected %0b, actual %0b",
                             $time, want.found, m_tdata[0]);
                    mismatch_count++;
                end
                if (m_tdata[POS_BITS:1] !== want.pos)
                begin
                    $display("%0t: position mismatch, expected %0d, actual %0d",
                             $time, want.pos, m_tdata[POS_BITS:1]);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver: stalls by style, or holds off for a requested number of cycles.
    initial
    begin : receiver
        logic [10:0] stall_pattern;
        int          pattern_idx;
        int          hold_len;
        stall_pattern = 11'b10110111011;
        pattern_idx   = 0;
        m_tready      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_len     = hold_request;
                hold_request = 0;
                m_tready <= 1'b0;
                repeat (hold_len) @(negedge clk);
            end
            else
            begin
                case (ready_style)
                    READY_ALWAYS:  m_tready <= 1'b1;
                    READY_RANDOM:  m_tready <= ($urandom_range(0, 99) < 70);
                    default:
                    begin
                        m_tready    <= stall_pattern[pattern_idx];
                        pattern_idx = (pattern_idx + 1) % 11;
                    end
                endcase
            end
        end
    end

    // Main sequence: reset, directed table, random phases.
    initial
    begin : main_sequence
        directed_row_t           row;
        logic [KEY_W-1:0]        key_pool [POOL_SIZE];
        logic [STRAT_BITS-1:0]   phase_strategy [PHASES];
        logic [ENTRIES_BITS-1:0] phase_entries [PHASES];
        logic [KEY_W-1:0]        key;
        logic [SLOT_BITS-1:0]    slot;
        int                      lim;
        int                      pick;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        mismatch_count = 0;
        burst_left     = 0;
        sender_paced   = 1'b1;
        ready_style    = READY_RANDOM;
        hold_request   = 0;
        cur_strategy   = STRATEGY_RESET;
        cur_entries    = ENTRIES_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_key[i]   = '0;
            shadow_valid[i] = 1'b0;
            shadow_count[i] = '0;
        end

        // Directed cases: empty table, extreme keys, each strategy, entry limits,
        // hit at the front, invalid neighbor under counting, duplicate keys.
        directed_rows = '{
            search_row(32'h0000_0000, 1'b1, 1'b0, 6'd0),
            search_row(32'hFFFF_FFFF, 1'b1, 1'b0, 6'd0),
            load_row(32'hFFFF_FFFF, 6'd63),
            load_row(32'h0000_0000, 6'd0),
            load_row(32'hA5A5_A5A5, 6'd1),
            search_row(32'hFFFF_FFFF, 1'b1, 1'b1, 6'd63),
            search_row(32'h0000_0000, 1'b1, 1'b1, 6'd63),
            write_row(REG_STRATEGY, 32'(STRAT_PREV)),
            load_row(32'h1234_5678, 6'd5),
            search_row(32'h1234_5678, 1'b1, 1'b1, 6'd5),
            search_row(32'h1234_5678, 1'b1, 1'b1, 6'd4),
            write_row(REG_STRATEGY, 32'(STRAT_COUNT)),
            search_row(32'h1234_5678, 1'b1, 1'b1, 6'd2),
            search_row(32'h0000_0000, 1'b1, 1'b1, 6'd0),
            search_row(32'hA5A5_A5A5, 1'b1, 1'b1, 6'd1),
            search_row(32'hA5A5_A5A5, 1'b1, 1'b1, 6'd0),
            write_row(REG_ENTRIES, 32'd0),
            search_row(32'hA5A5_A5A5, 1'b1, 1'b0, 6'd0),
            write_row(REG_ENTRIES, 32'd1),
            search_row(32'h0000_0000, 1'b1, 1'b0, 6'd0),
            write_row(REG_ENTRIES, 32'd127),
            search_row(32'hFFFF_FFFF, 1'b0, 1'b0, 6'd0),
            write_row(REG_STRATEGY, 32'(STRAT_UNUSED)),
            search_row(32'h1234_5678, 1'b1, 1'b1, 6'd2),
            search_row(32'hDEAD_BEEF, 1'b1, 1'b0, 6'd0),
            load_row(32'h0000_0000, 6'd40),
            search_row(32'h0000_0000, 1'b0, 1'b0, 6'd0)
        };

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE)
                write_register(row.reg_sel, row.value);
            else
                send_request(row.mode, row.key, row.slot, row.typed, row.found, row.pos);
        end

        // Random phases, each under its own register setting.
        phase_strategy = '{STRAT_COUNT, STRAT_FRONT, STRAT_PREV, STRAT_COUNT,
                           STRAT_UNUSED, STRAT_PREV, STRAT_COUNT};
        phase_entries  = '{7'd64, 7'd16, 7'd127, 7'd8, 7'd1, 7'd64, 7'd3};
        phase_entries[3] = 7'($urandom_range(2, 63));
        for (int p = 0; p < PHASES; p++)
        begin
            write_register(REG_STRATEGY, 32'(phase_strategy[p]));
            write_register(REG_ENTRIES, 32'(phase_entries[p]));
            sender_paced = (p != 5);
            ready_style  = (p == 5) ? READY_ALWAYS : ready_style_t'(1 + (p % 2));
            // Long receiver hold-off so the block fills up and stalls its input.
            if (p == 1)
                hold_request = 300;
            key_pool[0] = 32'h0000_0000;
            key_pool[1] = 32'hFFFF_FFFF;
            for (int k = 2; k < POOL_SIZE; k++)
                key_pool[k] = $urandom;
            lim = (phase_entries[p] > DEPTH) ? DEPTH : int'(phase_entries[p]);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                pick = $urandom_range(0, 99);
                key  = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                if ($urandom_range(0, 4) == 0)
                    slot = SLOT_BITS'($urandom_range(0, DEPTH - 1));
                else
                    slot = SLOT_BITS'($urandom_range(0, lim - 1));
                if (pick < 22)
                begin
                    if ($urandom_range(0, 9) < 3)
                        key = $urandom;
                    send_request(MODE_LOAD, key, slot, 1'b0, 1'b0, 6'd0);
                end
                else if (pick < 87)
                    send_request(MODE_SEARCH, key, SLOT_BITS'($urandom), 1'b0, 1'b0, 6'd0);
                else
                    send_request(MODE_SEARCH, $urandom, SLOT_BITS'($urandom), 1'b0, 1'b0,
                                 6'd0);
            end
        end

        await_idle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
